/* hw/rtl/rked_pkg.sv */
// remote key event decoder package: codes, widths and the keymap rom
// no dependencies
package rked_pkg;

  localparam int MAP_ENTRIES = 256;
  localparam int TIMER_BITS  = 16;
  localparam int KEY_BITS    = 12;
  localparam int REPORT_BITS = 25;

  localparam logic [7:0]  RELEASE_CODE_RST  = 8'hff;
  localparam logic [15:0] HOLD_DELAY_RST    = 16'd500;
  localparam logic [15:0] REPEAT_PERIOD_RST = 16'd50;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_HELD   = 2'd1,
    MODE_REPEAT = 2'd2
  } key_mode_t;

  typedef enum logic [1:0] {
    EV_RELEASE = 2'd0,
    EV_PRESS   = 2'd1,
    EV_REPEAT  = 2'd2
  } event_state_t;

  typedef enum logic [1:0] {
    REG_RELEASE_CODE  = 2'd0,
    REG_HOLD_DELAY    = 2'd1,
    REG_REPEAT_PERIOD = 2'd2
  } reg_index_t;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic                valid;
    logic [KEY_BITS-1:0] key;
  } map_entry_t;

  function automatic map_entry_t keymap_lookup(input logic [7:0] scan);
    map_entry_t e;
    e.valid = 1'b1;
    case (scan)
      8'h01, 8'h81: e.key = 12'd212;
      8'h02, 8'h82: e.key = 12'd103;
      8'h03, 8'h83: e.key = 12'd213;
      8'h04, 8'h84: e.key = 12'd28;
      8'h05, 8'h85: e.key = 12'd105;
      8'h06, 8'h86: e.key = 12'd158;
      8'h07, 8'h87: e.key = 12'd106;
      8'h1a, 8'h9a: e.key = 12'd108;
      8'h1b, 8'h9b: e.key = 12'd139;
      default: begin
        e.valid = 1'b0;
        e.key   = '0;
      end
    endcase
    if ({1'b0, scan} >= 9'(MAP_ENTRIES)) begin
      e.valid = 1'b0;
    end
    return e;
  endfunction

endpackage

/* hw/rtl/remote_key_event_decoder.sv */
// remote key event decoder top level: press, release and repeat events
// depends on rked_pkg
// result: an event of an accepted request is registered in the output register, or in the skid register under stall
// throughput: one request per cycle while the skid register is empty; a skid register absorbs one result under stall
// reset: synchronous active high rst; registers to reset values, key idle, no results
module remote_key_event_decoder
  import rked_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [3:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   operation,
  input  logic [7:0]             rx_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             event_state,
  output logic [7:0]             scan_code,
  output logic [KEY_BITS-1:0]    key_code,
  output logic [REPORT_BITS-1:0] report_word
);

  typedef struct packed {
    logic [1:0]             state;
    logic [7:0]             scan;
    logic [KEY_BITS-1:0]    key;
    logic [REPORT_BITS-1:0] report;
  } result_t;

  logic [7:0]  release_code;
  logic [15:0] hold_delay;
  logic [15:0] repeat_period;

  key_mode_t             key_mode, key_mode_next;
  logic [7:0]            held_scan, held_scan_next;
  logic [TIMER_BITS-1:0] quiet_ticks, quiet_ticks_next;

  logic                  accept;
  logic                  ev_fire;
  event_state_t          ev_state;
  logic [7:0]            ev_scan;
  map_entry_t            ev_entry;
  logic                  res_fire;
  result_t               res;
  logic [TIMER_BITS-1:0] ticks_inc;
  logic [15:0]           limit;

  result_t out_reg;
  logic    skid_valid;
  result_t skid_reg;

  // configuration port
  assign pready = 1'b1;
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      release_code  <= RELEASE_CODE_RST;
      hold_delay    <= HOLD_DELAY_RST;
      repeat_period <= REPEAT_PERIOD_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_RELEASE_CODE:  release_code  <= pwdata[7:0];
        REG_HOLD_DELAY:    hold_delay    <= pwdata[15:0];
        REG_REPEAT_PERIOD: repeat_period <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_RELEASE_CODE:  prdata = {24'd0, release_code};
      REG_HOLD_DELAY:    prdata = {16'd0, hold_delay};
      REG_REPEAT_PERIOD: prdata = {16'd0, repeat_period};
      default:           prdata = '0;
    endcase
  end

  assign in_stall = skid_valid;
  assign accept   = in_valid && !in_stall;

  assign ticks_inc = (quiet_ticks == '1) ? quiet_ticks : quiet_ticks + 1'b1;
  assign limit     = (key_mode == MODE_HELD) ? hold_delay : repeat_period;

  // next state
  always_comb begin
    key_mode_next    = key_mode;
    held_scan_next   = held_scan;
    quiet_ticks_next = quiet_ticks;
    if (accept) begin
      if (operation == OP_BYTE) begin
        quiet_ticks_next = '0;
        if (key_mode == MODE_IDLE) begin
          if (rx_byte != release_code) begin
            held_scan_next = rx_byte;
            key_mode_next  = MODE_HELD;
          end
        end else if (rx_byte == release_code) begin
          held_scan_next = '0;
          key_mode_next  = MODE_IDLE;
        end
      end else begin
        quiet_ticks_next = ticks_inc;
        if (key_mode != MODE_IDLE) begin
          if (32'(ticks_inc) >= 32'(limit) || ticks_inc == '1) begin
            quiet_ticks_next = '0;
            key_mode_next    = MODE_REPEAT;
          end
        end
      end
    end
  end

  // event outputs
  always_comb begin
    ev_fire  = 1'b0;
    ev_state = EV_PRESS;
    ev_scan  = rx_byte;
    if (operation == OP_BYTE) begin
      if (key_mode == MODE_IDLE) begin
        ev_fire  = rx_byte != release_code;
        ev_state = EV_PRESS;
        ev_scan  = rx_byte;
      end else begin
        ev_fire  = rx_byte == release_code;
        ev_state = EV_RELEASE;
        ev_scan  = held_scan;
      end
    end else if (key_mode != MODE_IDLE) begin
      ev_fire  = 32'(ticks_inc) >= 32'(limit) || ticks_inc == '1;
      ev_state = EV_REPEAT;
      ev_scan  = held_scan;
    end
  end

  assign ev_entry   = keymap_lookup(ev_scan);
  assign res_fire   = accept && ev_fire && ev_entry.valid;
  assign res.state  = ev_state;
  assign res.scan   = ev_scan;
  assign res.key    = ev_entry.key;
  assign res.report = {ev_state != EV_RELEASE, 4'd0, ev_scan, ev_entry.key};

  always_ff @(posedge clk) begin
    if (rst) begin
      key_mode    <= MODE_IDLE;
      held_scan   <= '0;
      quiet_ticks <= '0;
    end else begin
      key_mode    <= key_mode_next;
      held_scan   <= held_scan_next;
      quiet_ticks <= quiet_ticks_next;
    end
  end

  // output register with skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_fire;
      end
    end else if (res_fire) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_reg <= skid_reg;
      end else if (res_fire) begin
        out_reg <= res;
      end
    end else if (res_fire) begin
      skid_reg <= res;
    end
  end

  assign event_state = out_reg.state;
  assign scan_code   = out_reg.scan;
  assign key_code    = out_reg.key;
  assign report_word = out_reg.report;

`ifndef ASSERT_OFF
  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a result while output register is empty");

  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_idle_scan_clear: assert property (@(posedge clk) disable iff (rst)
    key_mode == MODE_IDLE |-> held_scan == 8'd0)
    else $error("held scan code not cleared while idle");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    skid_valid && out_stall |=> skid_valid)
    else $error("skid result lost under stall");
`endif

endmodule

/* sim/rked_checker.sv */
// checker for the remote key event decoder: tracks register writes, predicts the
// press, release and repeat events of every accepted request and compares the results
// depends on rked_pkg
`timescale 1ns / 100ps

module rked_checker
  import rked_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        operation,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  event_state,
  input  logic [7:0]  scan_code,
  input  logic [11:0] key_code,
  input  logic [24:0] report_word,
  output int          fail_count,
  output int          events_due
);

  typedef struct packed {
    logic [1:0]  ev_state;
    logic [7:0]  scan;
    logic [11:0] key;
    logic [24:0] report;
  } key_event_t;

  key_event_t  due_events[$];
  int          fails = 0;

  logic [7:0]  rel_code;
  logic [15:0] hold_ticks;
  logic [15:0] repeat_ticks;
  key_mode_t   mode_now;
  logic [7:0]  held_code;
  logic [15:0] quiet_count;

  // {valid, key}; the top bit of the scan code does not change the key
  function automatic logic [12:0] key_for_scan(input logic [7:0] scan);
    logic [12:0] hit;
    case (scan[6:0])
      7'h01:   hit = {1'b1, 12'd212};
      7'h02:   hit = {1'b1, 12'd103};
      7'h03:   hit = {1'b1, 12'd213};
      7'h04:   hit = {1'b1, 12'd28};
      7'h05:   hit = {1'b1, 12'd105};
      7'h06:   hit = {1'b1, 12'd158};
      7'h07:   hit = {1'b1, 12'd106};
      7'h1a:   hit = {1'b1, 12'd108};
      7'h1b:   hit = {1'b1, 12'd139};
      default: hit = '0;
    endcase
    return hit;
  endfunction

  function automatic bit build_event(input event_state_t st, input logic [7:0] scan,
                                     output key_event_t ev);
    logic [12:0] hit;
    hit = key_for_scan(scan);
    ev = '0;
    if (!hit[12]) return 1'b0;
    ev.ev_state = st;
    ev.scan     = scan;
    ev.key      = hit[11:0];
    ev.report   = {(st != EV_RELEASE), 4'h0, scan, hit[11:0]};
    return 1'b1;
  endfunction

  function automatic bit decode_request(input logic op, input logic [7:0] b,
                                        output key_event_t ev);
    logic [15:0] limit;
    logic [7:0]  scan;
    ev = '0;
    if (op == OP_BYTE) begin
      quiet_count = '0;
      if (mode_now == MODE_IDLE) begin
        if (b == rel_code) return 1'b0;
        held_code = b;
        mode_now  = MODE_HELD;
        return build_event(EV_PRESS, b, ev);
      end
      if (b != rel_code) return 1'b0;
      scan      = held_code;
      held_code = '0;
      mode_now  = MODE_IDLE;
      return build_event(EV_RELEASE, scan, ev);
    end
    if (quiet_count != '1) quiet_count = quiet_count + 16'd1;
    if (mode_now == MODE_IDLE) return 1'b0;
    limit = (mode_now == MODE_HELD) ? hold_ticks : repeat_ticks;
    if (quiet_count >= limit || quiet_count == '1) begin
      quiet_count = '0;
      mode_now    = MODE_REPEAT;
      return build_event(EV_REPEAT, held_code, ev);
    end
    return 1'b0;
  endfunction

  task automatic flag_mismatch(input string what, input longint want, input longint got);
    $display("%0t: %s mismatch, expected 0x%0h got 0x%0h", $time, what, want, got);
    fails++;
  endtask

  always @(posedge clk) begin : watch
    key_event_t ev;
    key_event_t want;
    if (rst) begin
      rel_code     = RELEASE_CODE_RST;
      hold_ticks   = HOLD_DELAY_RST;
      repeat_ticks = REPEAT_PERIOD_RST;
      mode_now     = MODE_IDLE;
      held_code    = '0;
      quiet_count  = '0;
      due_events.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_RELEASE_CODE:  rel_code     = pwdata[7:0];
          REG_HOLD_DELAY:    hold_ticks   = pwdata[15:0];
          REG_REPEAT_PERIOD: repeat_ticks = pwdata[15:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (decode_request(operation, rx_byte, ev)) due_events.push_back(ev);
      end
      if (out_valid && !out_stall) begin
        if (due_events.size() == 0) begin
          $display("%0t: unexpected result, expected none got state %0d scan 0x%0h",
                   $time, event_state, scan_code);
          fails++;
        end else begin
          want = due_events.pop_front();
          if (event_state != want.ev_state)
            flag_mismatch("event_state", want.ev_state, event_state);
          if (scan_code != want.scan) flag_mismatch("scan_code", want.scan, scan_code);
          if (key_code != want.key) flag_mismatch("key_code", want.key, key_code);
          if (report_word != want.report)
            flag_mismatch("report_word", want.report, report_word);
        end
      end
    end
    events_due <= due_events.size();
    fail_count <= fails;
  end

endmodule

/* sim/tb_top.sv */
// testbench top for the remote key event decoder: clock, reset, register writes,
// directed and random byte and tick requests, receiver stalls and the verdict
// depends on rked_pkg, remote_key_event_decoder and rked_checker
`timescale 1ns / 100ps

module tb_top;
  import rked_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 700;

  localparam logic [7:0] MAPPED_CODES [18] = '{
    8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h1a, 8'h1b,
    8'h81, 8'h82, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87, 8'h9a, 8'h9b
  };

  logic        clk;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        operation = OP_BYTE;
  logic [7:0]  rx_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  event_state;
  logic [7:0]  scan_code;
  logic [KEY_BITS-1:0]    key_code;
  logic [REPORT_BITS-1:0] report_word;

  int          fail_count;
  int          events_due;
  int          cycles = 0;
  int          req_count = 0;
  int          burst_left = 0;
  int          stall_left = 0;
  int          stall_mode = 0;
  logic [7:0]  release_now = RELEASE_CODE_RST;

  remote_key_event_decoder dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .operation(operation), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall), .event_state(event_state),
    .scan_code(scan_code), .key_code(key_code), .report_word(report_word)
  );

  rked_checker u_checker (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .operation(operation), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall), .event_state(event_state),
    .scan_code(scan_code), .key_code(key_code), .report_word(report_word),
    .fail_count(fail_count), .events_due(events_due)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver stall pattern: free, light, heavy or periodic, each held for a while
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= (cycles[3:0] < 4'd11);
    endcase
  end

  task automatic send_req(input logic op, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 4);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? 100 : $urandom_range(1, 24);
    end
    burst_left--;
    operation <= op;
    rx_byte   <= b;
    in_valid  <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    req_count++;
  endtask

  task automatic drain_all();
    in_valid <= 1'b0;
    @(posedge clk);
    while (events_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_index_t idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    if (idx == REG_RELEASE_CODE) release_now = val[7:0];
  endtask

  function automatic logic [7:0] pick_scan();
    if ($urandom_range(0, 3) != 0) return MAPPED_CODES[$urandom_range(0, 17)];
    return 8'($urandom);
  endfunction

  task automatic random_config();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) cfg_write(REG_RELEASE_CODE, 32'hff);
    else if (r < 6) cfg_write(REG_RELEASE_CODE, 32'h00);
    else if (r < 8) cfg_write(REG_RELEASE_CODE, 32'(MAPPED_CODES[$urandom_range(0, 17)]));
    else cfg_write(REG_RELEASE_CODE, $urandom_range(0, 255));
    r = $urandom_range(0, 19);
    if (r < 3) cfg_write(REG_HOLD_DELAY, 32'd0);
    else if (r < 16) cfg_write(REG_HOLD_DELAY, $urandom_range(1, 10));
    else cfg_write(REG_HOLD_DELAY, $urandom_range(11, 40));
    r = $urandom_range(0, 9);
    if (r == 0) cfg_write(REG_REPEAT_PERIOD, 32'd0);
    else cfg_write(REG_REPEAT_PERIOD, $urandom_range(1, 6));
  endtask

  // mostly press, hold with ticks and stray bytes, then release; some plain noise
  task automatic random_phase(input int n);
    int stop_at;
    int steps;
    int r;
    stop_at = req_count + n;
    while (req_count < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6)) send_req(1'($urandom_range(0, 1)), 8'($urandom));
      end else begin
        send_req(OP_BYTE, pick_scan());
        steps = $urandom_range(0, 16);
        repeat (steps) begin
          r = $urandom_range(0, 99);
          if (r < 78) send_req(OP_TICK, 8'($urandom));
          else if (r < 92) send_req(OP_BYTE, 8'($urandom));
          else send_req(OP_BYTE, release_now);
        end
        if ($urandom_range(0, 4) != 0) send_req(OP_BYTE, release_now);
      end
      if ($urandom_range(0, 39) == 0) drain_all();
    end
  endtask

  initial begin
    int target;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // register reset values: press, noise, release, idle release and ticks, unmapped keys
    send_req(OP_BYTE, 8'h01);
    send_req(OP_BYTE, 8'h55);
    send_req(OP_BYTE, 8'hff);
    send_req(OP_BYTE, 8'hff);
    send_req(OP_TICK, 8'h00);
    send_req(OP_TICK, 8'hff);
    send_req(OP_BYTE, 8'h00);
    send_req(OP_BYTE, 8'hff);
    send_req(OP_BYTE, 8'h9b);
    send_req(OP_BYTE, 8'hff);
    send_req(OP_BYTE, 8'h80);
    send_req(OP_BYTE, 8'h7f);
    send_req(OP_BYTE, 8'hff);
    drain_all();

    // zero delay and period: repeat on every tick
    cfg_write(REG_RELEASE_CODE, 32'h00);
    cfg_write(REG_HOLD_DELAY, 32'd0);
    cfg_write(REG_REPEAT_PERIOD, 32'd0);
    send_req(OP_BYTE, 8'h87);
    send_req(OP_TICK, 8'h00);
    send_req(OP_TICK, 8'h00);
    send_req(OP_BYTE, 8'h00);
    drain_all();

    cfg_write(REG_RELEASE_CODE, 32'hff);
    cfg_write(REG_HOLD_DELAY, 32'd2);
    cfg_write(REG_REPEAT_PERIOD, 32'd3);
    send_req(OP_BYTE, 8'h1a);
    repeat (5) send_req(OP_TICK, 8'h00);
    send_req(OP_BYTE, 8'h04);
    send_req(OP_BYTE, 8'hff);
    drain_all();

    // longer delay then shorter period over a long hold
    cfg_write(REG_HOLD_DELAY, 32'd20);
    cfg_write(REG_REPEAT_PERIOD, 32'd7);
    send_req(OP_BYTE, 8'h83);
    repeat (40) send_req(OP_TICK, 8'h00);
    send_req(OP_BYTE, 8'hff);

    target = req_count + RANDOM_ITEMS;
    while (req_count < target) begin
      drain_all();
      random_config();
      random_phase($urandom_range(80, 160));
    end

    drain_all();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && events_due == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/rked_pkg.sv
hw/rtl/remote_key_event_decoder.sv
sim/rked_checker.sv
sim/tb_top.sv
